### rtl/dual_cpu_interrupt_mask_glue_top_assert.svh
// assertion macros used by dcimg_regs
`ifndef DUAL_CPU_INTERRUPT_MASK_GLUE_TOP_ASSERT_SVH
`define DUAL_CPU_INTERRUPT_MASK_GLUE_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define DCIMG_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("dcimg assertion failed");

// consequent holds in the cycle after the antecedent
`define DCIMG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dcimg assertion failed");

`endif

### rtl/dcimg_pkg.sv
package dcimg_pkg;

	localparam logic [3:0] FN_RD_MASK0  = 4'd0;
	localparam logic [3:0] FN_RD_MASK1  = 4'd1;
	localparam logic [3:0] FN_RD_SRC    = 4'd2;
	localparam logic [3:0] FN_RD_CROSS  = 4'd3;
	localparam logic [3:0] FN_WR_MASK0  = 4'd4;
	localparam logic [3:0] FN_WR_MASK1  = 4'd5;
	localparam logic [3:0] FN_WR_CROSS  = 4'd6;
	localparam logic [3:0] FN_WR_RESET  = 4'd7;
	localparam logic [3:0] FN_SRC_BIT   = 4'd8;

	localparam int SETCLR_BIT  = 31;
	localparam int REQ_CPU_BIT = 25;
	localparam int SMI0_BIT    = 30;
	localparam int SMI1_BIT    = 29;
	localparam int SYNC0_BIT   = 27;
	localparam int SYNC1_BIT   = 26;
	// reset register byte is write_word[31:24]
	localparam int RST_ENABLE_BIT  = 29;
	localparam int RST_RELEASE_BIT = 31;

	typedef struct packed {
		logic [3:0]  func;
		logic [31:0] write_word;
		logic [4:0]  source_index;
		logic        source_level;
		logic        requester_cpu;
	} req_t;

	typedef struct packed {
		logic [31:0] read_word;
		logic        irq_cpu_zero;
		logic        irq_cpu_one;
		logic        smi_cpu_zero;
		logic        smi_cpu_one;
		logic        sync_cpu_zero;
		logic        sync_cpu_one;
		logic        hold_cpu_one;
	} rsp_t;

	function automatic logic [31:0] setclr(input logic [31:0] target, input logic [31:0] w);
		logic [31:0] sel;
		sel = {1'b0, w[30:0]};
		if (w[SETCLR_BIT]) begin
			return target | sel;
		end
		return target & ~sel;
	endfunction

endpackage

### rtl/dcimg_req_if.sv
interface dcimg_req_if;
	logic              valid;
	logic              ready;
	dcimg_pkg::req_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/dcimg_rsp_if.sv
interface dcimg_rsp_if;
	logic              valid;
	logic              ready;
	dcimg_pkg::rsp_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/dcimg_regs.sv
`include "dual_cpu_interrupt_mask_glue_top_assert.svh"

module dcimg_regs (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  dcimg_pkg::req_t item,
	output dcimg_pkg::rsp_t result
);

	logic [31:0] mask0_q, mask1_q, src_q, cross_q;
	logic        held_q;
	logic [31:0] mask0_d, mask1_d, src_d, cross_d;
	logic        held_d;
	logic [31:0] rd;
	logic [31:0] src_bit;

	assign src_bit = 32'd1 << item.source_index;

	always_comb begin
		mask0_d = mask0_q;
		mask1_d = mask1_q;
		src_d   = src_q;
		cross_d = cross_q;
		held_d  = held_q;
		rd      = '0;
		unique case (item.func)
			dcimg_pkg::FN_RD_MASK0: rd = mask0_q;
			dcimg_pkg::FN_RD_MASK1: rd = mask1_q;
			dcimg_pkg::FN_RD_SRC:   rd = src_q;
			dcimg_pkg::FN_RD_CROSS: begin
				rd = cross_q;
				rd[dcimg_pkg::REQ_CPU_BIT] = item.requester_cpu;
			end
			dcimg_pkg::FN_WR_MASK0: mask0_d = dcimg_pkg::setclr(mask0_q, item.write_word);
			dcimg_pkg::FN_WR_MASK1: mask1_d = dcimg_pkg::setclr(mask1_q, item.write_word);
			dcimg_pkg::FN_WR_CROSS: cross_d = dcimg_pkg::setclr(cross_q, item.write_word);
			dcimg_pkg::FN_WR_RESET: begin
				if (item.write_word[dcimg_pkg::RST_ENABLE_BIT]) begin
					held_d = !item.write_word[dcimg_pkg::RST_RELEASE_BIT];
				end
			end
			dcimg_pkg::FN_SRC_BIT: begin
				if (item.source_level) begin
					src_d = src_q | src_bit;
				end else begin
					src_d = src_q & ~src_bit;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		result.read_word     = rd;
		result.irq_cpu_zero  = |(src_d & mask0_d);
		result.irq_cpu_one   = |(src_d & mask1_d);
		result.smi_cpu_zero  = cross_d[dcimg_pkg::SMI0_BIT];
		result.smi_cpu_one   = cross_d[dcimg_pkg::SMI1_BIT];
		result.sync_cpu_zero = !cross_d[dcimg_pkg::SYNC0_BIT];
		result.sync_cpu_one  = !cross_d[dcimg_pkg::SYNC1_BIT];
		result.hold_cpu_one  = held_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask0_q <= '0;
			mask1_q <= '0;
			src_q   <= '0;
			cross_q <= '0;
			held_q  <= 1'b1;
		end else if (en) begin
			mask0_q <= mask0_d;
			mask1_q <= mask1_d;
			src_q   <= src_d;
			cross_q <= cross_d;
			held_q  <= held_d;
		end
	end

	// set/clear writes never reach bit 31
	`DCIMG_ASSERT_ALWAYS(a_top_bit_fixed, !mask0_q[31] && !mask1_q[31] && !cross_q[31])
	`DCIMG_ASSERT_NEXT(a_held_only_by_rst, !(en && item.func == dcimg_pkg::FN_WR_RESET), $stable(held_q))
	`DCIMG_ASSERT_NEXT(a_src_only_by_event, !(en && item.func == dcimg_pkg::FN_SRC_BIT), $stable(src_q))
	`DCIMG_ASSERT_NEXT(a_idle_no_change, !en, $stable(mask0_q) && $stable(mask1_q) && $stable(cross_q))

endmodule

### rtl/dual_cpu_interrupt_mask_glue_top.sv
// interrupt mask glue for a two-processor board
// req channel: one item per register read, set/clear register write,
// reset register write or interrupt source bit change
// rsp channel: one item per request, carrying the read data (zero for
// non-reads) and all line levels (irq, smi, tlb sync, cpu1 hold) as they
// stand after the request took effect
// response path: a req item passes the input register, then the result
// register, before it shows on rsp; the register update happens as the
// item leaves the input register
// throughput: one item per cycle while rsp is not stalled, set by the single input register stage
// and the result register; back-to-back items see each other's updates
// when rsp is stalled the result register holds and the input register
// keeps one more item; req.ready drops only when both are full
// reset: masks, sources and cross-processor bits clear, cpu1 starts held,
// both channels empty
module dual_cpu_interrupt_mask_glue_top (
	input  logic           clk,
	input  logic           arst_n,
	dcimg_req_if.sink      req,
	dcimg_rsp_if.source    rsp
);

	logic            valid_s1;
	dcimg_pkg::req_t item_s1;
	logic            rsp_valid_q;
	dcimg_pkg::rsp_t rsp_data_q;
	dcimg_pkg::rsp_t result;
	logic            advance;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	dcimg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_data_q <= result;
		end
	end

endmodule
